### rtl/core/ascp_pkg.sv
// shared types and constants of the ascii step command parser
`timescale 1ns / 1ps
`default_nettype none
package ascp_pkg;

  localparam int unsigned ANGLE_W   = 31;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned STEPS_W   = 16;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = 1;
  localparam int unsigned CMD_CNT_W = 2;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = '1;
  localparam logic [STEP_W-1:0]  STEP_RESET = 16'd256;
  localparam logic [STEPS_W-1:0] POS_LIMIT  = 16'h7fff;
  localparam logic [STEPS_W-1:0] NEG_LIMIT  = 16'h8000;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_Y_LO  = 8'h79;
  localparam logic [7:0] CH_Y_UP  = 8'h59;
  localparam logic [7:0] CH_Z_LO  = 8'h7a;
  localparam logic [7:0] CH_Z_UP  = 8'h5a;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEERING = 2'd0,
    REG_THROTTLE = 2'd1,
    REG_BRAKES   = 2'd2
  } reg_idx_e;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_STEERING = 2'd0,
    AXIS_THROTTLE = 2'd1,
    AXIS_BRAKES   = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    axis_e              axis;
    logic [ANGLE_W-1:0] angle;
    logic               neg;
  } cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] steering;
    logic [STEP_W-1:0] throttle;
    logic [STEP_W-1:0] brakes;
  } step_cfg_t;

endpackage
`default_nettype wire

### rtl/core/ascp_front.sv
// character classifier and angle accumulator
`timescale 1ns / 1ps
`default_nettype none
module ascp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          char_i,
  output logic                cmd_push_o,
  output ascp_pkg::cmd_t      cmd_o
);
  import ascp_pkg::*;

  logic [ANGLE_W-1:0] angle_q, angle_d;
  logic               neg_q, neg_d;
  logic [ANGLE_W+3:0] mul10;
  logic               is_digit;

  assign is_digit = (char_i >= CH_0) && (char_i <= CH_9);
  assign mul10 = ({4'b0, angle_q} << 3) + ({4'b0, angle_q} << 1)
               + (ANGLE_W+4)'(char_i[3:0]);

  always_comb begin
    angle_d    = angle_q;
    neg_d      = neg_q;
    cmd_push_o = 1'b0;
    cmd_o.axis  = AXIS_STEERING;
    cmd_o.angle = angle_q;
    cmd_o.neg   = neg_q;
    if (acc_i) begin
      angle_d = '0;
      neg_d   = 1'b0;
      priority if (is_digit) begin
        angle_d = (|mul10[ANGLE_W+3:ANGLE_W]) ? ANGLE_MAX : mul10[ANGLE_W-1:0];
        neg_d   = neg_q;
      end else if (char_i == CH_MINUS) begin
        neg_d = 1'b1;
      end else if (char_i == CH_X_LO || char_i == CH_X_UP) begin
        cmd_push_o = 1'b1;
        cmd_o.axis = AXIS_STEERING;
      end else if (char_i == CH_Y_LO || char_i == CH_Y_UP) begin
        cmd_push_o = 1'b1;
        cmd_o.axis = AXIS_THROTTLE;
      end else if (char_i == CH_Z_LO || char_i == CH_Z_UP) begin
        cmd_push_o = 1'b1;
        cmd_o.axis = AXIS_BRAKES;
      end else begin
        angle_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      neg_q   <= 1'b0;
    end else begin
      angle_q <= angle_d;
      neg_q   <= neg_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ascp_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module ascp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ascp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ascp_pkg::cmd_t data_o
);
  import ascp_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_q, rd_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/ascp_div.sv
// bit-serial divider, sign and saturation, result register
`timescale 1ns / 1ps
`default_nettype none
module ascp_div #(
  parameter int unsigned STEP_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ascp_pkg::step_cfg_t                 cfg_i,
  input  logic                                cmd_valid_i,
  input  ascp_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  output logic                                res_valid_o,
  input  logic                                res_pop_i,
  output logic [ascp_pkg::AXIS_W-1:0]         axis_o,
  output logic signed [ascp_pkg::STEPS_W-1:0] steps_o
);
  import ascp_pkg::*;

  localparam int unsigned DW   = ANGLE_W + STEP_FRAC_BITS;
  localparam int unsigned CNTW = $clog2(DW + 1);

  div_state_e         state_q, state_d;
  logic [DW-1:0]      dvd_q, dvd_d;
  logic [STEP_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]  dvs_q, dvs_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  axis_e              axis_q, axis_d;
  logic               neg_q, neg_d;
  axis_e              res_axis_q;
  logic [STEPS_W-1:0] res_steps_q, res_steps;
  logic               res_valid_q, res_load;
  logic [STEP_W:0]    rem_sh, rem_sub;
  logic               ge;
  logic [STEP_W-1:0]  step_sel;
  logic [STEPS_W-1:0] limit, mag;

  always_comb begin
    unique case (cmd_i.axis)
      AXIS_STEERING: step_sel = cfg_i.steering;
      AXIS_THROTTLE: step_sel = cfg_i.throttle;
      AXIS_BRAKES:   step_sel = cfg_i.brakes;
      default:       step_sel = cfg_i.brakes;
    endcase
  end

  // a zero divisor leaves every quotient bit set, which saturates below
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  assign limit     = neg_q ? NEG_LIMIT : POS_LIMIT;
  assign mag       = (dvd_q > DW'(limit)) ? limit : dvd_q[STEPS_W-1:0];
  assign res_steps = neg_q ? (STEPS_W'(0) - mag) : mag;

  always_comb begin
    state_d   = state_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    cnt_d     = cnt_q;
    axis_d    = axis_q;
    neg_d     = neg_q;
    cmd_pop_o = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          dvd_d     = DW'(cmd_i.angle) << STEP_FRAC_BITS;
          rem_d     = '0;
          dvs_d     = step_sel;
          cnt_d     = CNTW'(DW);
          axis_d    = cmd_i.axis;
          neg_d     = cmd_i.neg;
          state_d   = DIV_RUN;
        end
      end
      DIV_RUN: begin
        dvd_d = {dvd_q[DW-2:0], ge};
        rem_d = ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (!res_valid_q || res_pop_i) begin
          res_load = 1'b1;
          state_d  = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DIV_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    cnt_q  <= cnt_d;
    axis_q <= axis_d;
    neg_q  <= neg_d;
    if (res_load) begin
      res_axis_q  <= axis_q;
      res_steps_q <= res_steps;
    end
  end

  assign res_valid_o = res_valid_q;
  assign axis_o      = res_axis_q;
  assign steps_o     = res_steps_q;

endmodule
`default_nettype wire

### rtl/core/ascii_axis_step_command_parser.sv
// top level of the ascii axis step command parser
`timescale 1ns / 1ps
`default_nettype none
// Takes one ASCII character per request through push/full and returns axis step
// commands through empty/pop. Digits, '-' and other characters are taken one per
// cycle while full is low. Each axis letter queues a command for the divider, which
// takes one quotient bit per cycle over a 31 + STEP_FRAC_BITS bit dividend, between
// its load and finish steps; the two-entry command queue lets characters keep
// arriving meanwhile, and full rises while it holds two commands. Step registers
// are written through cfg_we_i, cfg_addr_i and cfg_data_i.
module ascii_axis_step_command_parser #(
  parameter int unsigned STEP_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          char_code_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [ascp_pkg::AXIS_W-1:0]         axis_o,
  output logic signed [ascp_pkg::STEPS_W-1:0] steps_o,
  input  logic                                cfg_we_i,
  input  logic [ascp_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [ascp_pkg::STEP_W-1:0]         cfg_data_i
);
  import ascp_pkg::*;

  step_cfg_t cfg_q;
  logic      in_acc;
  logic      cmd_push, cmd_full, cmd_valid, cmd_pop, res_valid;
  cmd_t      cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steering <= STEP_RESET;
      cfg_q.throttle <= STEP_RESET;
      cfg_q.brakes   <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_STEERING: cfg_q.steering <= cfg_data_i;
        REG_THROTTLE: cfg_q.throttle <= cfg_data_i;
        REG_BRAKES:   cfg_q.brakes   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full   = cmd_full;
  assign in_acc = push && !cmd_full;
  assign empty  = !res_valid;

  ascp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .char_i     (char_code_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  ascp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  ascp_div #(
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_pop_i   (pop && !empty),
    .axis_o      (axis_o),
    .steps_o     (steps_o)
  );

`ifndef SYNTH
  a_axis_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (axis_o != 2'd3))
    else $error("result names no axis");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");
`endif

endmodule
`default_nettype wire

### sim/ascii_axis_step_command_parser_test.sv
// testbench of the ascii axis step command parser: table and random character requests
`timescale 1ns / 1ps
module ascii_axis_step_command_parser_test;
  import ascp_pkg::*;

  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned PHASE_ITEMS  = 220;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    axis_e                     axis;
    logic signed [STEPS_W-1:0] steps;
  } step_cmd_t;

  typedef struct packed {
    logic [7:0]                ch;
    logic                      typed;
    axis_e                     axis;
    logic signed [STEPS_W-1:0] steps;
  } stim_row_t;

  localparam logic [7:0] AXIS_LETTERS [6] = '{CH_X_LO, CH_X_UP, CH_Y_LO, CH_Y_UP,
                                               CH_Z_LO, CH_Z_UP};

  localparam stim_row_t DIRECTED_ROWS [31] = '{
    '{CH_X_LO,  1'b1, AXIS_STEERING, 16'sd0},
    '{"1",      1'b0, AXIS_STEERING, 16'sd0},
    '{"2",      1'b0, AXIS_STEERING, 16'sd0},
    '{"3",      1'b0, AXIS_STEERING, 16'sd0},
    '{CH_X_UP,  1'b1, AXIS_STEERING, 16'sd123},
    '{CH_MINUS, 1'b0, AXIS_STEERING, 16'sd0},
    '{"4",      1'b0, AXIS_STEERING, 16'sd0},
    '{"5",      1'b0, AXIS_STEERING, 16'sd0},
    '{CH_Y_LO,  1'b1, AXIS_THROTTLE, -16'sd45},
    // repeated minus
    '{CH_MINUS, 1'b0, AXIS_STEERING, 16'sd0},
    '{CH_MINUS, 1'b0, AXIS_STEERING, 16'sd0},
    '{"7",      1'b0, AXIS_STEERING, 16'sd0},
    '{CH_Y_UP,  1'b1, AXIS_THROTTLE, -16'sd7},
    // minus after digits drops them
    '{"1",      1'b0, AXIS_STEERING, 16'sd0},
    '{CH_MINUS, 1'b0, AXIS_STEERING, 16'sd0},
    '{"3",      1'b0, AXIS_STEERING, 16'sd0},
    '{CH_Z_LO,  1'b1, AXIS_BRAKES,   -16'sd3},
    // other characters clear angle and sign
    '{"5",      1'b0, AXIS_STEERING, 16'sd0},
    '{8'h00,    1'b0, AXIS_STEERING, 16'sd0},
    '{8'hff,    1'b0, AXIS_STEERING, 16'sd0},
    '{CH_Z_UP,  1'b1, AXIS_BRAKES,   16'sd0},
    '{CH_MINUS, 1'b0, AXIS_STEERING, 16'sd0},
    '{8'h80,    1'b0, AXIS_STEERING, 16'sd0},
    '{CH_X_LO,  1'b1, AXIS_STEERING, 16'sd0},
    '{"4",      1'b0, AXIS_STEERING, 16'sd0},
    '{"0",      1'b0, AXIS_STEERING, 16'sd0},
    '{"0",      1'b0, AXIS_STEERING, 16'sd0},
    '{"0",      1'b0, AXIS_STEERING, 16'sd0},
    '{"0",      1'b0, AXIS_STEERING, 16'sd0},
    '{CH_Y_LO,  1'b1, AXIS_THROTTLE, 16'sd32767},
    '{8'h2f,    1'b0, AXIS_STEERING, 16'sd0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic [7:0]                char_code_i = 8'h00;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [AXIS_W-1:0]         axis_o;
  logic signed [STEPS_W-1:0] steps_o;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_addr_i = REG_STEERING;
  logic [STEP_W-1:0]         cfg_data_i = '0;

  logic [ANGLE_W-1:0] parsed_angle = '0;
  logic               parsed_negative = 1'b0;
  logic [STEP_W-1:0]  step_size [3] = '{STEP_RESET, STEP_RESET, STEP_RESET};

  step_cmd_t pending_cmds [$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        quiet_cycles = 0;
  int        hold_off_cycles = 0;
  bit        idle_en = 1'b1;

  ascii_axis_step_command_parser #(
    .STEP_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .char_code_i(char_code_i),
    .empty      (empty),
    .pop        (pop),
    .axis_o     (axis_o),
    .steps_o    (steps_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit step_command_for(input logic [7:0] ch, output step_cmd_t cmd);
    logic [ANGLE_W+3:0] next_angle;
    logic [STEP_W-1:0]  step;
    logic [63:0]        quotient;
    logic [63:0]        limit;
    logic [STEPS_W-1:0] mag;
    cmd = '0;
    if (ch >= CH_0 && ch <= CH_9) begin
      next_angle = {4'd0, parsed_angle} * 35'd10 + 35'(ch - CH_0);
      parsed_angle = (next_angle > 35'(ANGLE_MAX)) ? ANGLE_MAX : next_angle[ANGLE_W-1:0];
      return 1'b0;
    end
    case (ch)
      CH_X_LO, CH_X_UP: begin
        cmd.axis = AXIS_STEERING;
        step = step_size[REG_STEERING];
      end
      CH_Y_LO, CH_Y_UP: begin
        cmd.axis = AXIS_THROTTLE;
        step = step_size[REG_THROTTLE];
      end
      CH_Z_LO, CH_Z_UP: begin
        cmd.axis = AXIS_BRAKES;
        step = step_size[REG_BRAKES];
      end
      CH_MINUS: begin
        parsed_angle = '0;
        parsed_negative = 1'b1;
        return 1'b0;
      end
      default: begin
        parsed_angle = '0;
        parsed_negative = 1'b0;
        return 1'b0;
      end
    endcase
    // a zero step counts as an infinitely small one
    if (step == '0) quotient = '1;
    else quotient = ({33'd0, parsed_angle} << FRAC_BITS) / {48'd0, step};
    limit = parsed_negative ? 64'({16'd0, NEG_LIMIT}) : 64'({16'd0, POS_LIMIT});
    mag = (quotient > limit) ? limit[STEPS_W-1:0] : quotient[STEPS_W-1:0];
    cmd.steps = parsed_negative ? (~mag + 16'd1) : mag;
    parsed_angle = '0;
    parsed_negative = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic typed = 1'b0,
                           input axis_e typed_axis = AXIS_STEERING,
                           input logic signed [STEPS_W-1:0] typed_steps = '0);
    step_cmd_t cmd;
    while (idle_en && $urandom_range(99) < 27) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    char_code_i <= ch;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    if (step_command_for(ch, cmd)) begin
      if (typed) begin
        cmd.axis = typed_axis;
        cmd.steps = typed_steps;
      end
      pending_cmds.push_back(cmd);
    end
  endtask

  task automatic send_random_sequence();
    int kind;
    int digits;
    kind = $urandom_range(99);
    if (kind < 72) begin
      if ($urandom_range(1) == 1) send_char(CH_MINUS);
      digits = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 5);
      repeat (digits) send_char(CH_0 + 8'($urandom_range(9)));
      send_char(AXIS_LETTERS[$urandom_range(5)]);
    end else if (kind < 85) begin
      send_char(8'($urandom));
    end else if (kind < 93) begin
      repeat ($urandom_range(1, 4)) send_char(CH_0 + 8'($urandom_range(9)));
      send_char(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) send_char(CH_0 + 8'($urandom_range(9)));
      repeat ($urandom_range(1, 2)) send_char(CH_MINUS);
      repeat ($urandom_range(0, 4)) send_char(CH_0 + 8'($urandom_range(9)));
      send_char(AXIS_LETTERS[$urandom_range(5)]);
    end
  endtask

  task automatic write_step(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx != REG_UNUSED) step_size[idx] = val;
  endtask

  task automatic set_steps(input logic [STEP_W-1:0] steering, input logic [STEP_W-1:0] throttle,
                           input logic [STEP_W-1:0] brakes);
    write_step(REG_STEERING, steering);
    write_step(REG_THROTTLE, throttle);
    write_step(REG_BRAKES, brakes);
    // out-of-range index must leave the steps alone
    write_step(REG_UNUSED, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        results_checked++;
        if (pending_cmds.size() == 0) begin
          $error("result with no pending request: axis %0d steps %0d", axis_o, steps_o);
          fail_count++;
        end else begin
          if (axis_o !== pending_cmds[0].axis) begin
            $error("axis mismatch: expected %0d, actual %0d", pending_cmds[0].axis, axis_o);
            fail_count++;
          end
          if (steps_o !== pending_cmds[0].steps) begin
            $error("steps mismatch: expected %0d, actual %0d", pending_cmds[0].steps, steps_o);
            fail_count++;
          end
          void'(pending_cmds.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      pop <= !idle_en || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED_ROWS[i]) begin
      send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].axis,
                DIRECTED_ROWS[i].steps);
    end
    settle();
    for (int phase = 1; phase <= 6; phase++) begin
      case (phase)
        1:       set_steps(16'd1, 16'hffff, 16'd0);
        2:       set_steps(16'd0, 16'd1, 16'hffff);
        default: set_steps(random_step(), random_step(), random_step());
      endcase
      idle_en = (phase != 2);
      // stall the result side long enough to back up the input
      if (phase == 3) hold_off_cycles = HOLD_CYCLES;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_sequence();
      settle();
    end
    $display("run covered %0d characters over 7 step settings, %0d step commands checked",
             items_sent, results_checked);
    if (fail_count == 0 && pending_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
